FILE: design/mef_pkg.sv
// shared constants and types for the majority element finder
// no dependencies; imported by majority_element_finder
package mef_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    // stream payload widths
    localparam int IN_TDATA_W   = DATA_W;
    localparam int OUT_TDATA_W  = ((DATA_W + 1 + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - DATA_W - 1;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [ADDR_W-1:0]        addr_t;

endpackage

FILE: design/mef_ram.sv
// generic simple dual-port ram with one write port and a registered read port
// no dependencies; used by majority_element_finder for the element store
module mef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/majority_element_finder.sv
// majority element finder: element store, counting sequencer and stream ports
// depends on mef_pkg and mef_ram
//
// Elements stream in one per cycle on the slave side and are written into a
// 1024-entry store; the transfer with tlast closes the set. Elements past the
// store capacity are dropped and reported in the overflow bit of the result.
// After the closing transfer the block counts, for every stored element, how
// many stored elements equal it, using the single read port of the store: one
// probe read, then one read per position. tready stays low during the whole
// pass; its final emit step is held for as long as the previous result still
// waits unaccepted in the output register. The result then sits in that output
// register and loading of the next set starts while it waits.
module majority_element_finder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mef_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // value
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mef_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // majority_value, overflow, zero pad
    output logic                          m_axis_tuser   // found
);

    import mef_pkg::*;

    localparam logic [2:0] ST_LOAD       = 3'd0;
    localparam logic [2:0] ST_PROBE_RD   = 3'd1;
    localparam logic [2:0] ST_PROBE_WAIT = 3'd2;
    localparam logic [2:0] ST_SCAN       = 3'd3;
    localparam logic [2:0] ST_EMIT       = 3'd4;

    logic [2:0] state_reg, state_next;
    cnt_t       fill_reg, fill_next;
    logic       drop_reg, drop_next;
    cnt_t       i_reg, i_next;
    cnt_t       j_reg, j_next;
    logic       pend_reg, pend_next;
    cnt_t       hits_reg, hits_next;
    elem_t      probe_reg, probe_next;
    cnt_t       best_cnt_reg, best_cnt_next;
    elem_t      best_val_reg, best_val_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_found_reg, out_found_next;
    elem_t      out_val_reg, out_val_next;
    logic       out_ovf_reg, out_ovf_next;

    logic       in_xfer;
    logic       mem_we;
    addr_t      mem_raddr;
    elem_t      mem_rdata;
    logic       found;

    mef_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (s_axis_tdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign mem_we        = in_xfer && (fill_reg < CNT_W'(MAX_ELEMENTS));
    assign mem_raddr     = (state_reg == ST_PROBE_RD) ? i_reg[ADDR_W-1:0]
                                                      : j_reg[ADDR_W-1:0];
    assign found         = (fill_reg != '0) && (best_cnt_reg > (fill_reg >> 1));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_ovf_reg, out_val_reg};

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        hits_next      = hits_reg;
        probe_next     = probe_reg;
        best_cnt_next  = best_cnt_reg;
        best_val_next  = best_val_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_val_next   = out_val_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (mem_we)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        i_next        = '0;
                        best_cnt_next = '0;
                        best_val_next = '0;
                        state_next    = ST_PROBE_RD;
                    end
                end
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_WAIT;
            end
            ST_PROBE_WAIT:
            begin
                probe_next = mem_rdata;
                j_next     = '0;
                pend_next  = 1'b0;
                hits_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (pend_reg && (mem_rdata == probe_reg))
                begin
                    hits_next = hits_reg + 1'b1;
                end
                if (j_reg < fill_reg)
                begin
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // scan of this probe complete
                if (!pend_reg && (j_reg == fill_reg))
                begin
                    if (hits_reg > best_cnt_reg)
                    begin
                        best_cnt_next = hits_reg;
                        best_val_next = probe_reg;
                    end
                    i_next = i_reg + 1'b1;
                    if ((i_reg + 1'b1) == fill_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_PROBE_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found;
                    out_val_next   = found ? best_val_reg : '0;
                    out_ovf_next   = drop_reg;
                    fill_next      = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            hits_reg      <= '0;
            best_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            hits_reg      <= hits_next;
            best_cnt_reg  <= best_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg     <= probe_next;
        best_val_reg  <= best_val_next;
        out_found_reg <= out_found_next;
        out_val_reg   <= out_val_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

FILE: sim/majority_element_finder_test.sv
// testbench for majority_element_finder: streams element sets, predicts each verdict
// and checks every result transfer; depends on mef_pkg and the design sources
module majority_element_finder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mef_pkg::*;

    localparam int WATCHDOG_LIMIT = 4_500_000;
    localparam int TAIL_CYCLES    = 50;
    localparam int RANDOM_ITEMS   = 600;
    localparam int OVF_BIT        = DATA_W;

    typedef struct {
        bit    found;
        elem_t value;
        bit    overflow;
    } verdict_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;     // value
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // majority_value, overflow, zero pad
    logic                   m_axis_tuser;           // found

    elem_t    set_elems[$];
    bit       set_dropped = 1'b0;
    verdict_t pending_verdicts[$];
    int       error_count = 0;
    int       burst_left  = 0;

    majority_element_finder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic verdict_t majority_of_set();
        int       n;
        int       hits;
        int       best_hits;
        int       best_pos;
        verdict_t v;
        n = set_elems.size();
        best_hits = 0;
        best_pos = 0;
        for (int i = 0; i < n; i++)
        begin
            hits = 0;
            for (int j = 0; j < n; j++)
            begin
                if (set_elems[j] == set_elems[i])
                    hits++;
            end
            if (hits > best_hits)
            begin
                best_hits = hits;
                best_pos = i;
            end
        end
        v.found = (n > 0) && (best_hits > n / 2);
        v.value = v.found ? set_elems[best_pos] : '0;
        v.overflow = set_dropped;
        return v;
    endfunction

    function automatic void load_element(elem_t v, bit is_last);
        if (set_elems.size() < MAX_ELEMENTS)
            set_elems.push_back(v);
        else
            set_dropped = 1'b1;
        if (is_last)
        begin
            pending_verdicts.push_back(majority_of_set());
            set_elems.delete();
            set_dropped = 1'b0;
        end
    endfunction

    task automatic send_elem(input elem_t v, input bit is_last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        load_element(v, is_last);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_set(input elem_t vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_elem(vals[i], i == vals.size() - 1);
    endtask

    task automatic wait_for_verdicts();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic shuffle_set(ref elem_t vals[$], input int n);
        int    j;
        elem_t tmp;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
    endtask

    task automatic build_random_set(ref elem_t vals[$], input int n);
        elem_t cand;
        elem_t alt;
        int    kind;
        int    k;
        vals.delete();
        cand = $urandom;
        alt = $urandom;
        kind = $urandom_range(0, 3);
        case (kind)
            0:       k = n / 2 + 1 + $urandom_range(0, n - n / 2 - 1);
            1:       k = n / 2;
            default: k = 0;
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i < k)
                vals.push_back(cand);
            else if (kind == 2)
                case ($urandom_range(0, 2))
                    0:       vals.push_back(cand);
                    1:       vals.push_back(alt);
                    default: vals.push_back(cand ^ elem_t'(1));
                endcase
            else if ($urandom_range(0, 1) == 1)
                vals.push_back(cand ^ (elem_t'(1) << $urandom_range(0, DATA_W - 1)));
            else
                vals.push_back($urandom);
        end
        shuffle_set(vals, n);
    endtask

    task automatic test_extremes();
        elem_t vals[$];
        vals = '{32'sh8000_0000};
        send_set(vals);
        vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
        send_set(vals);
        vals = '{0, -1, 0};
        send_set(vals);
        vals = '{32'sh0000_0001, 32'sh8000_0001};
        send_set(vals);
    endtask

    task automatic test_thresholds();
        elem_t vals[$];
        vals = '{5, 5, 6, 7};
        send_set(vals);
        vals = '{9, 1, 9, 2, 9};
        send_set(vals);
        vals = '{3, 4};
        send_set(vals);
        vals = '{8, 8};
        send_set(vals);
    endtask

    task automatic test_ties();
        elem_t vals[$];
        vals = '{11, 22, 11, 22, 33};
        send_set(vals);
        wait_for_verdicts();
    endtask

    task automatic test_overflow();
        elem_t vals[$];
        elem_t cand;
        cand = $urandom;
        for (int i = 0; i < MAX_ELEMENTS; i++)
            vals.push_back(i < MAX_ELEMENTS / 2 + 1 ? cand : elem_t'($urandom));
        shuffle_set(vals, MAX_ELEMENTS);
        vals.push_back(~cand);
        vals.push_back(~cand);
        send_set(vals);
        vals = '{7};
        send_set(vals);
    endtask

    task automatic test_random_sets();
        elem_t vals[$];
        int    sent;
        int    n;
        int    pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                n = $urandom_range(100, 160);
            else if (pick < 14)
                n = $urandom_range(13, 48);
            else
                n = $urandom_range(1, 12);
            build_random_set(vals, n);
            send_set(vals);
            sent += n;
            if ($urandom_range(0, 9) == 0)
                wait_for_verdicts();
        end
    endtask

    // receiver backpressure, in a randomly chosen stall mode that is redrawn when its run ends
    initial
    begin
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= (mode_left % 5 == 0);
                default: m_axis_tready <= (mode_left % 40 >= 30);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_verdicts
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result transfer, tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tuser !== want.found)
                begin
                    $display("%0t: found mismatch: expected %b, got %b",
                             $time, want.found, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[DATA_W-1:0] !== want.value)
                begin
                    $display("%0t: majority_value mismatch: expected %h, got %h",
                             $time, want.value, m_axis_tdata[DATA_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[OVF_BIT] !== want.overflow)
                begin
                    $display("%0t: overflow mismatch: expected %b, got %b",
                             $time, want.overflow, m_axis_tdata[OVF_BIT]);
                    error_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:OVF_BIT+1] !== '0)
                begin
                    $display("%0t: pad mismatch: expected 0, got %h",
                             $time, m_axis_tdata[OUT_TDATA_W-1:OVF_BIT+1]);
                    error_count++;
                end
            end
        end
    end

    // quiet cycle watchdog, the full-store counting pass is the longest quiet spell
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_thresholds();
        test_ties();
        test_overflow();
        test_random_sets();
        wait_for_verdicts();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
